### hw/rtl/gpe_pkg.sv
// Package for the glyph pixel expander: cell job type, code limits and 5x8 font ROM.
package gpe_pkg;

	localparam logic [7:0] CODE_LOW  = 8'd32;
	localparam logic [7:0] CODE_HIGH = 8'd90;
	localparam int         GLYPH_COUNT = 59;
	localparam int         CELL_COLS   = 5;
	localparam int         CELL_ROWS   = 8;
	localparam int         GLYPH_BITS  = CELL_COLS * CELL_ROWS;
	localparam logic [2:0] LAST_COL = 3'(CELL_COLS - 1);
	localparam logic [2:0] LAST_ROW = 3'(CELL_ROWS - 1);
	localparam int         QUEUE_DEPTH = 2;

	// One character cell as queued between front and back.
	// glyph[col*8 + row] is the bit for that pixel, columns already mirrored.
	typedef struct packed {
		logic [9:0]            ox;
		logic [9:0]            oy;
		logic [GLYPH_BITS-1:0] glyph;
		logic [15:0]           fg;
		logic [15:0]           bg;
	} glyph_job_t;

	// Each entry is the five font bytes in font order, byte 0 in the top bits.
	// Byte (4 - c) therefore lands at bits [c*8 +: 8].
	localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
		40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
		40'h12_2A_7F_2A_24, 40'h62_64_08_13_23, 40'h50_22_55_49_36, 40'h00_00_07_00_00,
		40'h00_41_22_1C_00, 40'h00_1C_22_41_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
		40'h00_30_40_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h02_04_08_10_20,
		40'h3E_45_49_51_3E, 40'h00_40_7F_42_00, 40'h46_49_51_61_42, 40'h31_4B_45_41_21,
		40'h10_7F_12_14_18, 40'h39_49_49_49_2F, 40'h30_49_49_4A_3C, 40'h03_05_09_71_01,
		40'h36_49_49_49_36, 40'h1E_29_49_49_0E, 40'h00_36_36_00_00, 40'h00_36_76_00_00,
		40'h00_41_22_14_08, 40'h14_14_14_14_14, 40'h08_14_22_41_00, 40'h06_09_51_01_06,
		40'h0E_49_4F_41_3E, 40'h7E_11_11_11_7E, 40'h36_49_49_49_7F, 40'h22_41_41_41_3E,
		40'h1C_22_41_41_7F, 40'h41_49_49_49_7F, 40'h01_09_09_09_7F, 40'h7A_49_49_41_3E,
		40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h01_3F_41_40_20, 40'h41_22_14_08_7F,
		40'h40_40_40_40_7F, 40'h7F_02_0C_02_7F, 40'h7F_10_0C_02_7F, 40'h3E_41_41_41_3E,
		40'h06_09_09_09_7F, 40'h5E_21_51_41_3E, 40'h46_29_19_09_7F, 40'h32_49_49_49_26,
		40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
		40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h43_45_49_51_61
	};

endpackage

### hw/rtl/glyph_pixel_expander_core.sv
// Top level of the glyph pixel expander: 5x8 character cell to pixel stream.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------------
//  input   | push / full        | origin_x, origin_y, char_code, fore_color, back_color
//  result  | empty / pop        | pixel_x, pixel_y, pixel_rgb, visible, last_pixel
//
// Each accepted character yields 40 pixel transactions, one per cycle while pop
// keeps the result moving; the pixel walker in gpe_back sets that pixel count.
// The first pixel of a cell appears once the cell has passed the job queue and the result stage.
// A two-entry job queue lets the next character be taken while one is walked.
// arst_n clears queue pointers, pixel counters and the result valid flag.
// A stalled result (pop low) holds the walker; the front stalls only when full.
module glyph_pixel_expander_core #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 135
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        push,
	output logic        full,
	input  logic [9:0]  origin_x,
	input  logic [9:0]  origin_y,
	input  logic [7:0]  char_code,
	input  logic [15:0] fore_color,
	input  logic [15:0] back_color,
	// result channel
	output logic        empty,
	input  logic        pop,
	output logic [10:0] pixel_x,
	output logic [10:0] pixel_y,
	output logic [15:0] pixel_rgb,
	output logic        visible,
	output logic        last_pixel
);
	import gpe_pkg::*;

	glyph_job_t new_job;
	glyph_job_t head_job;
	logic       head_valid;
	logic       job_done;

	// classify the code and fetch the mirrored glyph columns
	gpe_front u_front (
		.origin_x   (origin_x),
		.origin_y   (origin_y),
		.char_code  (char_code),
		.fore_color (fore_color),
		.back_color (back_color),
		.job        (new_job)
	);

	// decouples acceptance from the 40-pixel walk
	gpe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (push),
		.wr_job     (new_job),
		.full       (full),
		.rd_en      (job_done),
		.head       (head_job),
		.head_valid (head_valid)
	);

	// walks columns 0..4, rows 0..7 of the head job; pops it on the last pixel
	gpe_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_job),
		.head_valid  (head_valid),
		.job_done    (job_done),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_rgb   (pixel_rgb),
		.visible     (visible),
		.last_pixel  (last_pixel)
	);

endmodule

### hw/rtl/gpe_front.sv
// Front end: classifies the character code and fetches its glyph into a cell job.
module gpe_front (
	input  logic [9:0]          origin_x,
	input  logic [9:0]          origin_y,
	input  logic [7:0]          char_code,
	input  logic [15:0]         fore_color,
	input  logic [15:0]         back_color,
	output gpe_pkg::glyph_job_t job
);
	import gpe_pkg::*;

	logic       supported;
	logic [7:0] code_off;
	logic [5:0] entry;

	// unsupported codes fall back to the blank entry
	assign supported = (char_code >= CODE_LOW) && (char_code <= CODE_HIGH);
	assign code_off  = char_code - CODE_LOW;
	assign entry     = supported ? code_off[5:0] : 6'd0;

	always_comb begin
		job.ox    = origin_x;
		job.oy    = origin_y;
		job.glyph = GLYPH_ROM[entry];
		job.fg    = fore_color;
		job.bg    = back_color;
	end

endmodule

### hw/rtl/gpe_queue.sv
// Two-entry job queue between the front end and the pixel walker.
module gpe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  gpe_pkg::glyph_job_t wr_job,
	output logic                full,
	input  logic                rd_en,
	output gpe_pkg::glyph_job_t head,
	output logic                head_valid
);
	import gpe_pkg::*;

	glyph_job_t slot_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'(QUEUE_DEPTH));
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en && head_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en && !full, rd_en && head_valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> head_valid)
		else $error("job popped from empty queue");

endmodule

### hw/rtl/gpe_back.sv
// Back end: walks the 40 pixels of the head job into a registered result stage.
module gpe_back #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 135
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gpe_pkg::glyph_job_t head,
	input  logic                head_valid,
	output logic                job_done,
	output logic                empty,
	input  logic                pop,
	output logic [10:0]         pixel_x,
	output logic [10:0]         pixel_y,
	output logic [15:0]         pixel_rgb,
	output logic                visible,
	output logic                last_pixel
);
	import gpe_pkg::*;

	logic [2:0]  col_q;
	logic [2:0]  row_q;
	logic        out_valid_q;
	logic [10:0] px_q;
	logic [10:0] py_q;
	logic [15:0] color_q;
	logic        vis_q;
	logic        last_q;

	logic        advance;
	logic        step;
	logic        at_last;
	logic [10:0] px;
	logic [10:0] py;
	logic        bit_set;

	assign advance  = !out_valid_q || pop;
	assign step     = advance && head_valid;
	assign at_last  = (col_q == LAST_COL) && (row_q == LAST_ROW);
	assign job_done = step && at_last;

	assign px      = {1'b0, head.ox} + 11'(col_q);
	assign py      = {1'b0, head.oy} + 11'(row_q);
	assign bit_set = head.glyph[{col_q, row_q}];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			col_q       <= 3'd0;
			row_q       <= 3'd0;
		end else begin
			if (advance) begin
				out_valid_q <= head_valid;
			end
			if (step) begin
				if (at_last) begin
					col_q <= 3'd0;
					row_q <= 3'd0;
				end else if (row_q == LAST_ROW) begin
					col_q <= col_q + 3'd1;
					row_q <= 3'd0;
				end else begin
					row_q <= row_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			px_q    <= px;
			py_q    <= py;
			color_q <= bit_set ? head.fg : head.bg;
			vis_q   <= (px < 11'(SCREEN_WIDTH)) && (py < 11'(SCREEN_HEIGHT));
			last_q  <= at_last;
		end
	end

	assign empty       = !out_valid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_rgb   = color_q;
	assign visible     = vis_q;
	assign last_pixel  = last_q;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= LAST_COL)
		else $error("column counter out of range");

	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		job_done |=> (col_q == 3'd0) && (row_q == 3'd0) && last_pixel && !empty)
		else $error("counters did not wrap after last pixel");

endmodule
